FILE: rtl/core/q2e_pkg.sv
// ============================================================================
// q2e_pkg: shared types and constants of the quaternion to Euler converter
// Holds the CORDIC angle table, datapath widths and the structs that travel
// between the cells of the square root and CORDIC chains.
// ============================================================================
package q2e_pkg;

    // Working width of the CORDIC x and y words, with headroom for gain.
    localparam int CW = 36;

    // Digit steps of the square root; the radicand is 58 bits wide.
    localparam int SQRT_STEPS = 29;
    localparam int SQ_VAL_W   = 2 * SQRT_STEPS;
    localparam int SQ_ROOT_W  = SQRT_STEPS;
    localparam int SQ_REM_W   = SQRT_STEPS + 3;

    // atan(2^-i) in 32-bit binary angle units, 2^31 = pi.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          ang;
        logic                 zero;
    } cordic_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_VAL_W-1:0]  val;
    } sqrt_t;

endpackage

FILE: rtl/core/quaternion_to_euler_angles_top.sv
// ============================================================================
// quaternion_to_euler_angles_top: unit quaternion to 3-2-1 Euler angles
// Fully pipelined converter built from chains of square root and CORDIC cells.
// ============================================================================
//
//  Channel   Ports                                   Handshake
//  --------  --------------------------------------  -------------------------
//  request   quat_w, quat_x, quat_y, quat_z          start high, busy low
//  result    roll_angle, pitch_angle, yaw_angle,     done high for one cycle
//            pitch_clamped
//
// A new request is accepted in every clock cycle; busy is always low because
// nothing in the pipeline ever waits. Each result passes through one product
// stage, one sum stage, 29 square root cells, CORDIC_STAGES pitch CORDIC
// cells and one output register. The latency is set by the square root chain
// feeding the pitch CORDIC; roll and yaw run their CORDIC chains in parallel
// and wait in a delay line. The receiver cannot stall, so done simply marks
// each result for one cycle. Reset clears only the valid pipeline; data
// registers are not reset.
//
module quaternion_to_euler_angles_top
    import q2e_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               done,
    output logic signed [15:0] roll_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic               pitch_clamped
);

    localparam int S    = CORDIC_STAGES;
    localparam int LAT  = S + 32;
    localparam int CDLY = SQRT_STEPS + S;
    localparam int KEEP = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
    localparam int DROP = 32 - KEEP;
    localparam logic [31:0] RND  = 32'd1 << (DROP - 1);
    localparam logic [31:0] MASK = ~((32'd1 << DROP) - 32'd1);
    localparam logic signed [CW-1:0] ONE_Q28 = CW'(268435456);
    localparam logic signed [33:0]   HALF_PI = 34'sd1073741824;

    // Round half up to KEEP bits and return the upper 16 bits.
    function automatic logic [15:0] angle_round(input logic [31:0] a);
        logic [31:0] r;
        r = (a + RND) & MASK;
        return r[31:16];
    endfunction

    // Pre-rotates a vector into the right half plane.
    function automatic cordic_t cordic_prep(input logic signed [CW-1:0] xv,
                                            input logic signed [CW-1:0] yv);
        cordic_t c;
        c.zero = (xv == '0) && (yv == '0);
        if (xv[CW-1])
        begin
            c.x   = -xv;
            c.y   = -yv;
            c.ang = 32'h8000_0000;
        end
        else
        begin
            c.x   = xv;
            c.y   = yv;
            c.ang = '0;
        end
        return c;
    endfunction

    logic [LAT-1:0] vld_reg;

    // Product stage.
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg;
    logic signed [31:0] xy_reg, zz_reg, wy_reg, xz_reg;

    // Sum stage.
    cordic_t roll_init, yaw_init;
    sqrt_t   s_init, c_init;
    logic    clamp_init;

    logic signed [CW-1:0] roll_y, roll_x, yaw_y, yaw_x, t_raw, t_sat;
    logic [29:0]          arg_s, arg_c;
    logic                 clamp_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge clk)
    begin
        wx_reg <= quat_w * quat_x;
        yz_reg <= quat_y * quat_z;
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        wz_reg <= quat_w * quat_z;
        xy_reg <= quat_x * quat_y;
        zz_reg <= quat_z * quat_z;
        wy_reg <= quat_w * quat_y;
        xz_reg <= quat_x * quat_z;
    end

    always_comb
    begin
        roll_y = (CW'(wx_reg) + CW'(yz_reg)) <<< 1;
        roll_x = ONE_Q28 - ((CW'(xx_reg) + CW'(yy_reg)) <<< 1);
        yaw_y  = (CW'(wz_reg) + CW'(xy_reg)) <<< 1;
        yaw_x  = ONE_Q28 - ((CW'(yy_reg) + CW'(zz_reg)) <<< 1);
        t_raw  = (CW'(wy_reg) - CW'(xz_reg)) <<< 1;
        clamp_next = 1'b0;
        t_sat      = t_raw;
        if (t_raw > ONE_Q28)
        begin
            t_sat      = ONE_Q28;
            clamp_next = 1'b1;
        end
        else if (t_raw < -ONE_Q28)
        begin
            t_sat      = -ONE_Q28;
            clamp_next = 1'b1;
        end
        arg_s = 30'(ONE_Q28 + t_sat);
        arg_c = 30'(ONE_Q28 - t_sat);
    end

    always_ff @(posedge clk)
    begin
        roll_init  <= cordic_prep(roll_x, roll_y);
        yaw_init   <= cordic_prep(yaw_x, yaw_y);
        s_init     <= '{rem: '0, root: '0, val: {arg_s, 28'd0}};
        c_init     <= '{rem: '0, root: '0, val: {arg_c, 28'd0}};
        clamp_init <= clamp_next;
    end

    // Square root chains for sqrt(1+t) and sqrt(1-t).
    sqrt_t sq_s [SQRT_STEPS+1];
    sqrt_t sq_c [SQRT_STEPS+1];
    assign sq_s[0] = s_init;
    assign sq_c[0] = c_init;

    // CORDIC chains.
    cordic_t rc [S+1];
    cordic_t yc [S+1];
    cordic_t pc [S+1];
    assign rc[0] = roll_init;
    assign yc[0] = yaw_init;

    // Both roots are non-negative, so the pitch vector needs no pre-rotation.
    always_comb
    begin
        pc[0].x    = CW'(sq_c[SQRT_STEPS].root);
        pc[0].y    = CW'(sq_s[SQRT_STEPS].root);
        pc[0].ang  = '0;
        pc[0].zero = (sq_c[SQRT_STEPS].root == '0) && (sq_s[SQRT_STEPS].root == '0);
    end

    genvar gi;
    generate
        for (gi = 0; gi < SQRT_STEPS; gi++)
        begin : g_sqrt
            q2e_sqrt_cell u_sq_s (.clk(clk), .cin(sq_s[gi]), .cout(sq_s[gi+1]));
            q2e_sqrt_cell u_sq_c (.clk(clk), .cin(sq_c[gi]), .cout(sq_c[gi+1]));
        end
        for (gi = 0; gi < S; gi++)
        begin : g_cordic
            q2e_cordic_cell #(.STAGE_IDX(gi)) u_roll
                (.clk(clk), .cin(rc[gi]), .cout(rc[gi+1]));
            q2e_cordic_cell #(.STAGE_IDX(gi)) u_yaw
                (.clk(clk), .cin(yc[gi]), .cout(yc[gi+1]));
            q2e_cordic_cell #(.STAGE_IDX(gi)) u_pitch
                (.clk(clk), .cin(pc[gi]), .cout(pc[gi+1]));
        end
    endgenerate

    // Roll and yaw finish earlier than pitch and wait here.
    logic [31:0] roll_dly_reg [SQRT_STEPS];
    logic [31:0] yaw_dly_reg  [SQRT_STEPS];
    logic        clamp_dly_reg [CDLY];

    always_ff @(posedge clk)
    begin
        roll_dly_reg[0]  <= rc[S].zero ? 32'd0 : rc[S].ang;
        yaw_dly_reg[0]   <= yc[S].zero ? 32'd0 : yc[S].ang;
        clamp_dly_reg[0] <= clamp_init;
        for (int k = 1; k < SQRT_STEPS; k++)
        begin
            roll_dly_reg[k] <= roll_dly_reg[k-1];
            yaw_dly_reg[k]  <= yaw_dly_reg[k-1];
        end
        for (int k = 1; k < CDLY; k++)
        begin
            clamp_dly_reg[k] <= clamp_dly_reg[k-1];
        end
    end

    // Pitch is twice the CORDIC angle less a quarter turn, held to +-pi/2.
    logic [31:0]        pitch_a;
    logic signed [33:0] pitch_p;
    logic signed [33:0] pitch_sat;

    always_comb
    begin
        pitch_a = pc[S].zero ? 32'd0 : pc[S].ang;
        pitch_p = ({{2{pitch_a[31]}}, pitch_a} <<< 1) - HALF_PI;
        if (pitch_p > HALF_PI)
        begin
            pitch_sat = HALF_PI;
        end
        else if (pitch_p < -HALF_PI)
        begin
            pitch_sat = -HALF_PI;
        end
        else
        begin
            pitch_sat = pitch_p;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[LAT-2])
        begin
            roll_angle    <= angle_round(roll_dly_reg[SQRT_STEPS-1]);
            yaw_angle     <= angle_round(yaw_dly_reg[SQRT_STEPS-1]);
            pitch_angle   <= angle_round(pitch_sat[31:0]);
            pitch_clamped <= clamp_dly_reg[CDLY-1];
        end
    end

    assign done = vld_reg[LAT-1];

    // Every accepted request yields a result after the fixed latency.
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after request");

    // No result appears without a request the fixed latency earlier.
    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without request");

    // Pitch stays within a quarter turn either way.
    a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pitch_angle <= 16'sd16384 && pitch_angle >= -16'sd16384))
        else $error("pitch out of range");

endmodule

FILE: rtl/core/q2e_sqrt_cell.sv
// ============================================================================
// q2e_sqrt_cell: one digit step of the integer square root
// Takes the next two radicand bits and settles one root bit per cycle.
// ============================================================================
module q2e_sqrt_cell
    import q2e_pkg::*;
(
    input  logic  clk,
    input  sqrt_t cin,
    output sqrt_t cout
);

    logic [SQ_REM_W-1:0] rem_shift;
    logic [SQ_REM_W-1:0] trial;
    sqrt_t               cell_next;

    always_comb
    begin
        rem_shift = {cin.rem[SQ_REM_W-3:0], cin.val[SQ_VAL_W-1 -: 2]};
        trial     = {1'b0, cin.root, 2'b01};
        cell_next.val = {cin.val[SQ_VAL_W-3:0], 2'b00};
        if (rem_shift >= trial)
        begin
            cell_next.rem  = rem_shift - trial;
            cell_next.root = {cin.root[SQ_ROOT_W-2:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = rem_shift;
            cell_next.root = {cin.root[SQ_ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        cout <= cell_next;
    end

endmodule

FILE: rtl/core/q2e_cordic_cell.sv
// ============================================================================
// q2e_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward the x axis by atan(2^-i) and accumulates the angle.
// ============================================================================
module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int STAGE_IDX = 0
)
(
    input  logic    clk,
    input  cordic_t cin,
    output cordic_t cout
);

    localparam logic [4:0] TI = 5'(STAGE_IDX);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    cordic_t              cell_next;

    always_comb
    begin
        dx = cin.y >>> STAGE_IDX;
        dy = cin.x >>> STAGE_IDX;
        cell_next.zero = cin.zero;
        if (!cin.y[CW-1])
        begin
            cell_next.x   = cin.x + dx;
            cell_next.y   = cin.y - dy;
            cell_next.ang = cin.ang + ATAN_TAB[TI];
        end
        else
        begin
            cell_next.x   = cin.x - dx;
            cell_next.y   = cin.y + dy;
            cell_next.ang = cin.ang - ATAN_TAB[TI];
        end
    end

    always_ff @(posedge clk)
    begin
        cout <= cell_next;
    end

endmodule
